// ----- sv/dma_priority_queue_and_irq_regs_assert.svh -----
// ----------------------------------------------------------------------------
// dma priority queue assertion macros
// concurrent check macros for the dma priority queue rtl
// ----------------------------------------------------------------------------
`ifndef DMA_PRIORITY_QUEUE_AND_IRQ_REGS_ASSERT_SVH
`define DMA_PRIORITY_QUEUE_AND_IRQ_REGS_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dpq assertion failed");
// next-cycle implication
`define DPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dpq assertion failed");
`else
`define DPQ_ASSERT_NOW(label, clk, rst, ante, cons)
`define DPQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- sv/dpq_pkg.sv -----
// ----------------------------------------------------------------------------
// dpq_pkg
// shared types, command codes and constants of the dma priority queue
// ----------------------------------------------------------------------------
package dpq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 7;

   localparam logic [31:0] CTRL_RESET = 32'h0765_4321;
   localparam logic [2:0]  CHAN_NONE  = 3'd7;   // channel code that is not a dma channel

   localparam logic SEL_CTRL = 1'b0;
   localparam logic SEL_IRQ  = 1'b1;

   typedef enum logic [2:0] {
      CMD_READ       = 3'd0,
      CMD_WRITE      = 3'd1,
      CMD_START      = 3'd2,
      CMD_DONE       = 3'd3,
      CMD_COMPLETION = 3'd4,
      CMD_BUS_ERROR  = 3'd5
   } command_type;

   // one queue slot: stored priority and channel
   typedef struct packed {
      logic [2:0] prio;
      logic [2:0] chan;
   } entry_type;

   // broadcast from the queue control to every cell
   typedef struct packed {
      logic      insert;
      logic      pop;
      entry_type entry;
   } cell_ctl_type;

   // register block status for the current beat
   typedef struct packed {
      logic        start_ok;
      logic [2:0]  prio;
      logic [31:0] read_data;
      logic        irq_pulse;
   } regs_status_type;

endpackage

// ----- sv/dpq_cell.sv -----
// ----------------------------------------------------------------------------
// dpq_cell
// one slot of the sorted queue, shifts with its neighbors on insert and pop
// ----------------------------------------------------------------------------
module dpq_cell #(
   parameter int QUEUE_DEPTH = dpq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int INDEX       = 0
) (
   input  logic                               clock,
   input  dpq_pkg::cell_ctl_type              ctl,
   input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   count,
   input  logic                               prev_ahead,
   input  dpq_pkg::entry_type                 prev_entry,
   input  dpq_pkg::entry_type                 next_entry,
   output dpq_pkg::entry_type                 entry,
   output logic                               ahead
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   dpq_pkg::entry_type entry_ff;
   dpq_pkg::entry_type entry_in;
   logic               occupied;

   assign occupied = count > CNT_W'(INDEX);

   // lower priority value first, higher channel wins a tie
   assign ahead = occupied &&
      ((entry_ff.prio < ctl.entry.prio) ||
       ((entry_ff.prio == ctl.entry.prio) && (entry_ff.chan > ctl.entry.chan)));

   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert) begin
         if (!ahead) begin
            entry_in = prev_ahead ? ctl.entry : prev_entry;
         end
      end else if (ctl.pop) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ----- sv/dpq_regs.sv -----
// ----------------------------------------------------------------------------
// dpq_regs
// priority/enable control register and interrupt register
// ----------------------------------------------------------------------------
module dpq_regs (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [2:0]               command,
   input  logic                     reg_select,
   input  logic [31:0]              write_data,
   input  logic [2:0]               channel,
   output dpq_pkg::regs_status_type status
);

   logic [31:0] ctrl_ff, ctrl_in;
   logic [31:0] irq_ff, irq_in;
   logic [31:0] irq_work;
   logic [31:0] read_data;
   logic        recompute;
   logic        start_ok;
   logic [7:0]  irq_en_ext;
   logic [7:0]  flag_set;
   logic        master;

   assign irq_en_ext = {1'b0, irq_ff[22:16]};
   assign flag_set   = 8'b1 << channel;

   always_comb begin
      ctrl_in   = ctrl_ff;
      irq_work  = irq_ff;
      recompute = 1'b0;
      start_ok  = 1'b0;
      case (command)
         dpq_pkg::CMD_READ: begin
            recompute = (reg_select == dpq_pkg::SEL_IRQ);
         end
         dpq_pkg::CMD_WRITE: begin
            if (reg_select == dpq_pkg::SEL_CTRL) begin
               ctrl_in = write_data;
            end else begin
               // write one to a flag acknowledges it
               irq_work  = {irq_ff[31], irq_ff[30:24] & ~write_data[30:24], write_data[23:0]};
               recompute = 1'b1;
            end
         end
         dpq_pkg::CMD_START: begin
            start_ok = (channel != dpq_pkg::CHAN_NONE) && ctrl_ff[{channel, 2'b11}];
         end
         dpq_pkg::CMD_COMPLETION: begin
            if ((channel != dpq_pkg::CHAN_NONE) && irq_en_ext[channel]) begin
               irq_work[30:24] = irq_ff[30:24] | flag_set[6:0];
            end
            recompute = 1'b1;
         end
         dpq_pkg::CMD_BUS_ERROR: begin
            irq_work[15] = 1'b1;
            recompute    = 1'b1;
         end
         default: begin
         end
      endcase
      // bus error, or master enable with any enabled flag
      master = irq_work[15] || (irq_work[23] && (|(irq_work[22:16] & irq_work[30:24])));
      irq_in = recompute ? {master, irq_work[30:0]} : irq_work;
   end

   always_comb begin
      read_data = '0;
      if (command == dpq_pkg::CMD_READ) begin
         read_data = (reg_select == dpq_pkg::SEL_CTRL) ? ctrl_ff : irq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= dpq_pkg::CTRL_RESET;
         irq_ff  <= '0;
      end else if (accept) begin
         ctrl_ff <= ctrl_in;
         irq_ff  <= irq_in;
      end
   end

   assign status.start_ok  = start_ok;
   assign status.prio      = ctrl_ff[{channel, 2'b00} +: 3];
   assign status.read_data = read_data;
   assign status.irq_pulse = !irq_ff[31] && irq_in[31];

endmodule

// ----- sv/dma_priority_queue_and_irq_regs.sv -----
// ----------------------------------------------------------------------------
// dma_priority_queue_and_irq_regs
// dma controller core: control and interrupt registers, sorted start queue
// ----------------------------------------------------------------------------
// usage
//   req channel: one beat per command (read, write, start, done, completion,
//   bus error) with register select, write word and channel number
//   rsp channel: exactly one beat per req beat, in order, carrying read data,
//   queue front, active count, irq pulse and overflow flag
//   latency: the rsp beat is valid the cycle after its req beat is taken
//   throughput: one beat per cycle while req_stall is low; the whole sorted insert
//   or pop is done by the cell row in the accepting cycle, so the next beat needs no wait
//   stall: req_stall is high while a finished rsp beat sits stalled, so a
//   req beat is taken only when the output register is free or drains
//   reset: synchronous; control register returns to its default priorities,
//   interrupt register clears, queue empties; req_stall is held high
//   during reset and no rsp beat is pending afterward
//   queue: a row of QUEUE_DEPTH cells; a start compares the new key in every
//   cell at once and the row shifts by one toward the tail, done shifts it
//   toward the head
// ----------------------------------------------------------------------------
`include "dma_priority_queue_and_irq_regs_assert.svh"

module dma_priority_queue_and_irq_regs #(
   parameter int QUEUE_DEPTH = dpq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request beats
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic        req_reg_select,
   input  logic [31:0] req_write_data,
   input  logic [2:0]  req_channel,
   // response beats
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic [2:0]  rsp_front_channel,
   output logic        rsp_front_valid,
   output logic [2:0]  rsp_active_count,
   output logic        rsp_irq_pulse,
   output logic        rsp_queue_overflow
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic                     accept;
   dpq_pkg::regs_status_type regs_status;
   dpq_pkg::cell_ctl_type    cell_ctl;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W+2:0]   count_ext;
   logic               full;
   logic               is_start, is_done;
   logic               overflow_in;

   logic               rsp_valid_ff;
   logic [31:0]        read_data_ff;
   logic               irq_pulse_ff;
   logic               overflow_ff;

   // cell row wiring
   dpq_pkg::entry_type     cell_entry [QUEUE_DEPTH];
   dpq_pkg::entry_type     prev_entry [QUEUE_DEPTH];
   dpq_pkg::entry_type     next_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_ahead;
   logic [QUEUE_DEPTH-1:0] prev_ahead;

   // handshake: output register frees as soon as the rsp beat leaves
   assign req_stall = reset || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   dpq_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .command    (req_command),
      .reg_select (req_reg_select),
      .write_data (req_write_data),
      .channel    (req_channel),
      .status     (regs_status)
   );

   // queue control
   assign full        = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign is_start    = (req_command == dpq_pkg::CMD_START);
   assign is_done     = (req_command == dpq_pkg::CMD_DONE);
   assign overflow_in = regs_status.start_ok && full;

   assign cell_ctl.insert     = accept && is_start && regs_status.start_ok && !full;
   assign cell_ctl.pop        = accept && is_done && (count_ff != '0);
   assign cell_ctl.entry.prio = regs_status.prio;
   assign cell_ctl.entry.chan = req_channel;

   always_comb begin
      count_in = count_ff;
      if (cell_ctl.insert) begin
         count_in = count_ff + 1'b1;
      end else if (cell_ctl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // row of cells, head at index zero
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
         assign prev_ahead[g] = 1'b1;
         assign prev_entry[g] = cell_ctl.entry;
      end else begin : g_body
         assign prev_ahead[g] = cell_ahead[g-1];
         assign prev_entry[g] = cell_entry[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_tail
         assign next_entry[g] = cell_entry[g];
      end else begin : g_link
         assign next_entry[g] = cell_entry[g+1];
      end

      dpq_cell #(
         .QUEUE_DEPTH (QUEUE_DEPTH),
         .INDEX       (g)
      ) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl),
         .count      (count_ff),
         .prev_ahead (prev_ahead[g]),
         .prev_entry (prev_entry[g]),
         .next_entry (next_entry[g]),
         .entry      (cell_entry[g]),
         .ahead      (cell_ahead[g])
      );
   end

   // output register for the per-beat fields
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_data_ff <= regs_status.read_data;
         irq_pulse_ff <= regs_status.irq_pulse;
         overflow_ff  <= is_start && overflow_in;
      end
   end

   // queue status is read straight from state, which only moves on accept
   assign count_ext = {3'b000, count_ff};

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = read_data_ff;
   assign rsp_front_valid    = (count_ff != '0);
   assign rsp_front_channel  = (count_ff != '0) ? cell_entry[0].chan : 3'b000;
   assign rsp_active_count   = count_ext[2:0];
   assign rsp_irq_pulse      = irq_pulse_ff;
   assign rsp_queue_overflow = overflow_ff;

   // checks
   `DPQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   `DPQ_ASSERT_NEXT(a_count_hold, clock, reset, !accept, $stable(count_ff))
   `DPQ_ASSERT_NEXT(a_overflow_full, clock, reset, accept && is_start && overflow_in, count_ff == CNT_W'(QUEUE_DEPTH))
   `DPQ_ASSERT_NEXT(a_pop_count, clock, reset, cell_ctl.pop, count_ff == $past(count_ff) - 1'b1)

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// checks the dma priority queue and irq register core against a predictor
// that keeps its own control word, interrupt word and sorted start queue;
// directed beats cover reset values, ordering, overflow and irq edges, then
// a long random mix of commands runs with random gaps and stalls
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH        = dpq_pkg::QUEUE_DEPTH_DEFAULT;
   localparam int GAP_MAX      = 18;
   localparam int IDLE_LIMIT   = 1000;   // far above the worst gap plus stall
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_BEATS = 1380;

   // command codes the block ignores
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   // interrupt word layout
   localparam int BUS_ERR_BIT   = 15;
   localparam int IRQ_EN_LSB    = 16;
   localparam int MASTER_EN_BIT = 23;
   localparam int FLAG_LSB      = 24;
   localparam int MASTER_BIT    = 31;

   // one rsp beat, fields in port order
   typedef struct packed {
      logic [31:0] read_data;
      logic [2:0]  front_channel;
      logic        front_valid;
      logic [2:0]  active_count;
      logic        irq_pulse;
      logic        queue_overflow;
   } rsp_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_command = dpq_pkg::CMD_READ;
   logic        req_reg_select = dpq_pkg::SEL_CTRL;
   logic [31:0] req_write_data = '0;
   logic [2:0]  req_channel = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_read_data;
   logic [2:0]  rsp_front_channel;
   logic        rsp_front_valid;
   logic [2:0]  rsp_active_count;
   logic        rsp_irq_pulse;
   logic        rsp_queue_overflow;

   // predictor copy of the block state
   logic [31:0] ctrl_word = dpq_pkg::CTRL_RESET;
   logic [31:0] irq_word = '0;
   logic [2:0]  slot_chan [DEPTH];
   logic [2:0]  slot_prio [DEPTH];
   int          slot_count = 0;

   rsp_beat_type awaited_rsp [$];
   int fail_count = 0;
   int idle_cycles = 0;
   int req_calm = 0;
   int rsp_calm = 0;

   dma_priority_queue_and_irq_regs dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_reg_select     (req_reg_select),
      .req_write_data     (req_write_data),
      .req_channel        (req_channel),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_data      (rsp_read_data),
      .rsp_front_channel  (rsp_front_channel),
      .rsp_front_valid    (rsp_front_valid),
      .rsp_active_count   (rsp_active_count),
      .rsp_irq_pulse      (rsp_irq_pulse),
      .rsp_queue_overflow (rsp_queue_overflow)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // master flag: bus error, or master enable with any enabled flag
   function automatic void refresh_master();
      logic [6:0] enables;
      logic [6:0] flags;
      enables = irq_word[IRQ_EN_LSB +: 7];
      flags = irq_word[FLAG_LSB +: 7];
      irq_word[MASTER_BIT] = irq_word[BUS_ERR_BIT] |
                             (irq_word[MASTER_EN_BIT] & (|(enables & flags)));
   endfunction

   // sorted insert, returns 0 when the queue is full
   function automatic logic enqueue_start(logic [2:0] ch);
      logic [2:0] prio;
      int pos;
      int i;
      prio = ctrl_word[4 * ch +: 3];
      if (slot_count >= DEPTH) return 1'b0;
      pos = slot_count;
      // walk back past every entry that does not stay ahead of the new one;
      // lower priority value wins, on a tie the higher channel wins
      while (pos > 0 && !(slot_prio[pos - 1] < prio ||
                          (slot_prio[pos - 1] == prio && slot_chan[pos - 1] > ch)))
         pos--;
      for (i = slot_count; i > pos; i--) begin
         slot_chan[i] = slot_chan[i - 1];
         slot_prio[i] = slot_prio[i - 1];
      end
      slot_chan[pos] = ch;
      slot_prio[pos] = prio;
      slot_count++;
      return 1'b1;
   endfunction

   function automatic void pop_front_slot();
      int i;
      if (slot_count == 0) return;
      for (i = 0; i + 1 < slot_count; i++) begin
         slot_chan[i] = slot_chan[i + 1];
         slot_prio[i] = slot_prio[i + 1];
      end
      slot_count--;
   endfunction

   function automatic rsp_beat_type next_dma_response(logic [2:0] cmd, logic sel,
                                                       logic [31:0] wd, logic [2:0] ch);
      rsp_beat_type r;
      logic was_high;
      logic [6:0] kept_flags;
      r = '0;
      was_high = irq_word[MASTER_BIT];
      case (cmd)
         dpq_pkg::CMD_READ: begin
            if (sel == dpq_pkg::SEL_CTRL) begin
               r.read_data = ctrl_word;
            end else begin
               refresh_master();
               r.read_data = irq_word;
            end
         end
         dpq_pkg::CMD_WRITE: begin
            if (sel == dpq_pkg::SEL_CTRL) begin
               ctrl_word = wd;
            end else begin
               // ones in the flag field acknowledge, then the master bit is recomputed
               kept_flags = irq_word[FLAG_LSB +: 7] & ~wd[FLAG_LSB +: 7];
               irq_word = {irq_word[MASTER_BIT], kept_flags, wd[23:0]};
               refresh_master();
            end
         end
         dpq_pkg::CMD_START: begin
            if (ch != dpq_pkg::CHAN_NONE && ctrl_word[4 * ch + 3])
               r.queue_overflow = !enqueue_start(ch);
         end
         dpq_pkg::CMD_DONE: begin
            pop_front_slot();
         end
         dpq_pkg::CMD_COMPLETION: begin
            if (ch != dpq_pkg::CHAN_NONE && irq_word[IRQ_EN_LSB + ch])
               irq_word[FLAG_LSB + ch] = 1'b1;
            refresh_master();
         end
         dpq_pkg::CMD_BUS_ERROR: begin
            irq_word[BUS_ERR_BIT] = 1'b1;
            refresh_master();
         end
         default: ;
      endcase
      r.front_valid = slot_count > 0;
      r.front_channel = slot_count > 0 ? slot_chan[0] : 3'd0;
      r.active_count = 3'(slot_count);
      r.irq_pulse = !was_high && irq_word[MASTER_BIT];
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // monitor and checker
   // ---------------------------------------------------------------------

   function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_beat_type seen;
      rsp_beat_type want;
      if (!reset) begin
         // rsp beat taken at this edge
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_read_data, rsp_front_channel, rsp_front_valid,
                    rsp_active_count, rsp_irq_pulse, rsp_queue_overflow};
            if (awaited_rsp.size() == 0) begin
               $display("%0t: rsp beat expected none actual %0h", $time, seen);
               fail_count++;
            end else begin
               want = awaited_rsp.pop_front();
               check_field("read_data", want.read_data, seen.read_data);
               check_field("front_channel", want.front_channel, seen.front_channel);
               check_field("front_valid", want.front_valid, seen.front_valid);
               check_field("active_count", want.active_count, seen.active_count);
               check_field("irq_pulse", want.irq_pulse, seen.irq_pulse);
               check_field("queue_overflow", want.queue_overflow, seen.queue_overflow);
            end
         end
         // req beat taken at this edge: predict its response
         if (req_valid && !req_stall)
            awaited_rsp.push_back(next_dma_response(req_command, req_reg_select,
                                                    req_write_data, req_channel));
      end
      // watchdog count of cycles with no beat on either side
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      @(posedge clock);
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // gaps and stalls
   // ---------------------------------------------------------------------

   // wait before the next beat; now and then a calm stretch with no gaps
   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 31) == 0) calm_left = $urandom_range(16, 64);
      if ($urandom_range(0, 1) == 0) return $urandom_range(0, 2);
      return $urandom_range(0, GAP_MAX);
   endfunction

   // receiver: stall a random number of cycles, then take one beat
   initial begin
      int hold;
      @(posedge clock);
      forever begin
         hold = draw_gap(rsp_calm);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // sender: optional gap, then hold the beat until it is taken
   task automatic send_beat(logic [2:0] cmd, logic sel, logic [31:0] wd, logic [2:0] ch);
      int gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_reg_select <= sel;
      req_write_data <= wd;
      req_channel <= ch;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset contents and beats that must leave everything alone
   task automatic test_reset_state();
      send_beat(dpq_pkg::CMD_READ, dpq_pkg::SEL_CTRL, $urandom(), 3'd0);
      send_beat(dpq_pkg::CMD_READ, dpq_pkg::SEL_IRQ, $urandom(), 3'd0);
      send_beat(dpq_pkg::CMD_DONE, dpq_pkg::SEL_CTRL, $urandom(), 3'd0); // done on empty
      send_beat(CMD_SPARE_6, dpq_pkg::SEL_IRQ, $urandom(), 3'd2);
      send_beat(CMD_SPARE_7, dpq_pkg::SEL_CTRL, $urandom(), 3'd5);
      send_beat(dpq_pkg::CMD_START, dpq_pkg::SEL_CTRL, $urandom(), dpq_pkg::CHAN_NONE);
      send_beat(dpq_pkg::CMD_COMPLETION, dpq_pkg::SEL_IRQ, $urandom(), dpq_pkg::CHAN_NONE);
   endtask

   // sorted insert with ties, then a start against a full queue
   task automatic test_queue_fill();
      logic [2:0] order [DEPTH];
      int i;
      order = '{3'd3, 3'd0, 3'd6, 3'd1, 3'd5, 3'd2, 3'd4};
      // all enabled; priorities 4,0,6,2,4,0,7 for channels 0..6
      send_beat(dpq_pkg::CMD_WRITE, dpq_pkg::SEL_CTRL, 32'hFF8C_AE8C, 3'd0);
      for (i = 0; i < DEPTH; i++)
         send_beat(dpq_pkg::CMD_START, dpq_pkg::SEL_CTRL, $urandom(), order[i]);
      // full queue drops it
      send_beat(dpq_pkg::CMD_START, dpq_pkg::SEL_IRQ, $urandom(), 3'd1);
   endtask

   // flag set, master edge, acknowledge, bus error
   task automatic test_interrupt_flags();
      // enables and master enable
      send_beat(dpq_pkg::CMD_WRITE, dpq_pkg::SEL_IRQ, 32'h00FF_0000, 3'd0);
      send_beat(dpq_pkg::CMD_COMPLETION, dpq_pkg::SEL_CTRL, $urandom(), 3'd3);
      send_beat(dpq_pkg::CMD_READ, dpq_pkg::SEL_IRQ, $urandom(), 3'd0);
      // ack all, master enable off
      send_beat(dpq_pkg::CMD_WRITE, dpq_pkg::SEL_IRQ, 32'h7F7F_0000, 3'd0);
      send_beat(dpq_pkg::CMD_COMPLETION, dpq_pkg::SEL_IRQ, $urandom(), 3'd5);
      send_beat(dpq_pkg::CMD_BUS_ERROR, dpq_pkg::SEL_CTRL, $urandom(), 3'd6);
      // bus error cleared
      send_beat(dpq_pkg::CMD_WRITE, dpq_pkg::SEL_IRQ, 32'h0000_0000, 3'd0);
      // enable clear, no flag
      send_beat(dpq_pkg::CMD_COMPLETION, dpq_pkg::SEL_CTRL, $urandom(), 3'd2);
   endtask

   // random command mix, starts and dones weighted so the queue moves
   task automatic test_random_traffic(int beats);
      int n;
      int pick;
      logic [2:0] cmd;
      logic sel;
      logic [31:0] wd;
      logic [2:0] ch;
      for (n = 0; n < beats; n++) begin
         pick = $urandom_range(0, 99);
         sel = 1'($urandom_range(0, 1));
         wd = $urandom();
         ch = ($urandom_range(0, 15) == 0) ? dpq_pkg::CHAN_NONE : 3'($urandom_range(0, 6));
         if (pick < 34) begin
            cmd = dpq_pkg::CMD_START;
         end else if (pick < 60) begin
            cmd = dpq_pkg::CMD_DONE;
         end else if (pick < 72) begin
            cmd = dpq_pkg::CMD_COMPLETION;
         end else if (pick < 80) begin
            cmd = dpq_pkg::CMD_READ;
         end else if (pick < 88) begin
            cmd = dpq_pkg::CMD_WRITE;
            sel = dpq_pkg::SEL_CTRL;
            case ($urandom_range(0, 9))
               0: wd = 32'h0000_0000;
               1: wd = 32'hFFFF_FFFF;
               2, 3, 4: wd = wd | 32'h8888_8888;   // every channel enabled
               default: ;
            endcase
         end else if (pick < 95) begin
            // mostly keep bus error clear and master enable set so edges recur
            cmd = dpq_pkg::CMD_WRITE;
            sel = dpq_pkg::SEL_IRQ;
            wd[BUS_ERR_BIT] = ($urandom_range(0, 7) == 0);
            wd[MASTER_EN_BIT] = ($urandom_range(0, 3) != 0);
         end else if (pick < 98) begin
            cmd = dpq_pkg::CMD_BUS_ERROR;
         end else begin
            cmd = $urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7;
         end
         send_beat(cmd, sel, wd, ch);
      end
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_queue_fill();
      test_interrupt_flags();
      test_random_traffic(RANDOM_BEATS);

      // stop sending, let every awaited beat arrive, then watch a little longer
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_rsp.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ----- dma_priority_queue_and_irq_regs.f -----
+incdir+sv
sv/dpq_pkg.sv
sv/dpq_cell.sv
sv/dpq_regs.sv
sv/dma_priority_queue_and_irq_regs.sv
test/tb.sv
